// ===== design/differential_drive_odometry_macros.svh =====
// Assertion macros shared by the odometry RTL.
// Depends on signals named clock and reset in the module that expands them.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define DDO_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("odometry check failed: same-cycle implication");
// next-cycle implication
`define DDO_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("odometry check failed: next-cycle implication");
`else
`define DDO_ASSERT_IMP(lbl, ante, cons)
`define DDO_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/ddo_pkg.sv =====
// Shared types, codes and constants of the differential drive odometry block.
// No dependencies; imported by ddo_mac, ddo_cordic and the top level.
package ddo_pkg;

   // default sizes of the tick counters and the heading
   localparam int COUNT_BITS_DEF = 16;
   localparam int ANGLE_BITS_DEF = 16;

   // configuration registers
   localparam int CFG_W     = 24;
   localparam int CSR_IDX_W = 1;
   localparam logic [CFG_W-1:0] MM_PER_TICK_RST      = 24'd65536;
   localparam logic [CFG_W-1:0] HEADING_PER_TICK_RST = 24'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MM_PER_TICK      = 1'b0,
      CSR_HEADING_PER_TICK = 1'b1
   } csr_index_type;

   // request kinds
   typedef enum logic [1:0] {
      ACT_LEFT   = 2'd0,
      ACT_RIGHT  = 2'd1,
      ACT_UPDATE = 2'd2
   } action_type;

   // shared multiplier: 34-bit signed by 17-bit signed chunk, two chunks per product
   localparam int MAC_A_W   = 34;
   localparam int MAC_B_W   = 17;
   localparam int MAC_CHUNK = 16;
   localparam int MAC_ACC_W = 66;

   // rounding shifts of the heading, distance and position products
   localparam int HEAD_SHIFT = 8;
   localparam int DIST_SHIFT = 9;
   localparam int POS_SHIFT  = 30;

   typedef enum logic [1:0] {
      RND_HEAD = 2'd0,
      RND_DIST = 2'd1,
      RND_POS  = 2'd2
   } rnd_type;

   typedef struct packed {
      logic    mul_en;
      logic    acc_en;
      logic    acc_first;
      logic    acc_last;
      rnd_type rnd;
   } mac_ctl_type;

   // CORDIC
   localparam int CORDIC_STEPS  = 24;
   localparam int CORDIC_STEP_W = $clog2(CORDIC_STEPS);
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_stat_type;

   // half an output LSB, added before the arithmetic shift
   function automatic logic signed [MAC_ACC_W-1:0] rnd_bias(input rnd_type rnd);
      logic signed [MAC_ACC_W-1:0] b;
      b = '0;
      case (rnd)
         RND_HEAD: b[HEAD_SHIFT-1] = 1'b1;
         RND_DIST: b[DIST_SHIFT-1] = 1'b1;
         RND_POS:  b[POS_SHIFT-1]  = 1'b1;
         default:  b = '0;
      endcase
      return b;
   endfunction

   // arctangent table, 32-bit binary angle with a quarter turn at 2^30
   function automatic logic signed [31:0] cordic_atan(input logic [CORDIC_STEP_W-1:0] idx);
      logic signed [31:0] a;
      case (idx)
         5'd0:    a = 32'sd536870912;
         5'd1:    a = 32'sd316933406;
         5'd2:    a = 32'sd167458907;
         5'd3:    a = 32'sd85004756;
         5'd4:    a = 32'sd42667331;
         5'd5:    a = 32'sd21354465;
         5'd6:    a = 32'sd10679838;
         5'd7:    a = 32'sd5340245;
         5'd8:    a = 32'sd2670163;
         5'd9:    a = 32'sd1335087;
         5'd10:   a = 32'sd667544;
         5'd11:   a = 32'sd333772;
         5'd12:   a = 32'sd166886;
         5'd13:   a = 32'sd83443;
         5'd14:   a = 32'sd41722;
         5'd15:   a = 32'sd20861;
         5'd16:   a = 32'sd10430;
         5'd17:   a = 32'sd5215;
         5'd18:   a = 32'sd2608;
         5'd19:   a = 32'sd1304;
         5'd20:   a = 32'sd652;
         5'd21:   a = 32'sd326;
         5'd22:   a = 32'sd163;
         5'd23:   a = 32'sd81;
         default: a = 32'sd0;
      endcase
      return a;
   endfunction

endpackage

// ===== design/differential_drive_odometry.sv =====
// Top level of the differential drive odometry block: tick counters, pose state,
// update sequencer. Depends on ddo_pkg, ddo_mac, ddo_cordic and the macros.
//
// Usage:
//  - req channel: req_tuser holds the kind (left edge, right edge, update),
//    req_tdata the encoder levels A and B. An edge request updates one wheel's
//    saturating tick counter in the cycle it is taken and yields no response.
//  - An update request takes and clears both counters, advances the heading,
//    moves the position and yields one rsp item with the pose and tick counts.
//  - csr port: one write per cycle, index 0 travel per tick, 1 heading per tick.
//  - Timing: an edge request is taken in ST_IDLE; req_tready stays high, so
//    edges run back to back. An update holds req_tready low until its response
//    is loaded and rsp_tvalid set: four two-pass products on the shared 34x17
//    multiplier (MUL, ACC, MUL, ACC, POST each) and a run of the 24-step CORDIC.
//  - Reset (synchronous, active high) clears counters, pose and heading and
//    loads the register defaults.
//  - A response waits in its output register while rsp_tready is low; new
//    edges are still taken, and a following update holds at its end until the
//    waiting response has been taken.
`include "differential_drive_odometry_macros.svh"
module differential_drive_odometry #(
   parameter int COUNT_BITS = ddo_pkg::COUNT_BITS_DEF,
   parameter int ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // enc_a, enc_b, zero pad
   input  logic [1:0]                           req_tuser,   // action
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pos_x_out, pos_y_out, heading_out, left_delta, right_delta
   output logic [111:0]                         rsp_tdata,
   input  logic                                 csr_we,
   input  logic [ddo_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ddo_pkg::CFG_W-1:0]            csr_wdata
);
   import ddo_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_ACC  = 6'b000100,
      ST_POST = 6'b001000,
      ST_CORD = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      OP_HEAD = 2'd0,
      OP_DIST = 2'd1,
      OP_X    = 2'd2,
      OP_Y    = 2'd3
   } op_type;

   localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
   localparam int DQ_W = MAC_ACC_W - DIST_SHIFT;
   localparam int PS_W = MAC_ACC_W - POS_SHIFT;
   localparam logic signed [MAC_A_W-1:0] DU_HI = MAC_A_W'(64'sd4294967296);
   localparam logic signed [MAC_A_W-1:0] DU_LO = MAC_A_W'(-64'sd4294967296);

   state_type                     state_ff, state_in;
   op_type                        op_ff, op_in;
   logic                          chunk_ff, chunk_in;
   logic [CFG_W-1:0]              mm_per_tick_ff, heading_per_tick_ff;
   logic signed [COUNT_BITS-1:0]  left_count_ff, left_count_in;
   logic signed [COUNT_BITS-1:0]  right_count_ff, right_count_in;
   logic signed [COUNT_BITS-1:0]  take_l_ff, take_r_ff;
   logic signed [MAC_A_W-1:0]     sum_ff, diff_ff;
   logic signed [MAC_A_W-1:0]     du_ff, du_in, du_c;
   logic [ANGLE_BITS-1:0]         heading_ff, heading_in;
   logic signed [31:0]            pos_x_ff, pos_x_in;
   logic signed [31:0]            pos_y_ff, pos_y_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [111:0]                  rsp_data_ff;
   logic                          rsp_load;
   logic                          take_update;
   logic                          same;
   action_type                    req_action;

   mac_ctl_type                   mac_ctl;
   logic signed [MAC_A_W-1:0]     mac_a;
   logic signed [MAC_B_W-1:0]     mac_b;
   logic signed [MAC_ACC_W-1:0]   mac_acc;

   logic                          cordic_start;
   logic signed [31:0]            sin_q30, cos_q30;
   cordic_stat_type               cstat;

   logic signed [DQ_W-1:0]        dq;
   logic signed [PS_W-1:0]        pos_step;
   logic signed [31:0]            pos_base, pos_sum;
   logic signed [31:0]            trig;
   logic [CFG_W-1:0]              cfg_mul;
   logic [ANGLE_BITS+15:0]        hd_wide;

   // saturating one-tick counter step
   function automatic logic signed [COUNT_BITS-1:0] cnt_step(
      input logic signed [COUNT_BITS-1:0] v, input logic up);
      logic signed [COUNT_BITS-1:0] r;
      r = v;
      if (up && v != CNT_MAX) begin
         r = v + 1'b1;
      end else if (!up && v != CNT_MIN) begin
         r = v - 1'b1;
      end
      return r;
   endfunction

   // clamp a tick count to the 16-bit report range
   function automatic logic [15:0] sat16(input logic signed [32:0] v);
      logic [15:0] r;
      if (v > 33'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -33'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // add the rounded step to a coordinate and saturate to 32 bits
   function automatic logic signed [31:0] sat_add(
      input logic signed [31:0] p, input logic signed [PS_W-1:0] t);
      logic signed [PS_W:0] s;
      logic signed [31:0]   r;
      s = (PS_W+1)'(p) + (PS_W+1)'(t);
      if (s > (PS_W+1)'(32'sh7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (s < (PS_W+1)'(32'sh8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   function automatic rnd_type rnd_of(input op_type op);
      rnd_type r;
      case (op)
         OP_HEAD: r = RND_HEAD;
         OP_DIST: r = RND_DIST;
         default: r = RND_POS;
      endcase
      return r;
   endfunction

   assign req_action = action_type'(req_tuser);
   assign same       = (req_tdata[0] == req_tdata[1]);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // multiplier operands for the current product and chunk
   always_comb begin
      case (op_ff)
         OP_HEAD: mac_a = diff_ff;
         OP_DIST: mac_a = sum_ff;
         default: mac_a = du_ff;
      endcase
      cfg_mul = (op_ff == OP_HEAD) ? heading_per_tick_ff : mm_per_tick_ff;
      trig    = (op_ff == OP_X) ? sin_q30 : cos_q30;
      if (op_ff == OP_HEAD || op_ff == OP_DIST) begin
         mac_b = chunk_ff ? {1'b0, cfg_mul[15:0]} : {9'b0, cfg_mul[23:16]};
      end else begin
         mac_b = chunk_ff ? {1'b0, trig[15:0]} : {trig[31], trig[31:16]};
      end
   end

   // post-processing of the accumulated product
   always_comb begin
      dq = mac_acc[MAC_ACC_W-1:DIST_SHIFT];
      if (dq > DQ_W'(DU_HI)) begin
         du_c = DU_HI;
      end else if (dq < DQ_W'(DU_LO)) begin
         du_c = DU_LO;
      end else begin
         du_c = dq[MAC_A_W-1:0];
      end
      pos_step = mac_acc[MAC_ACC_W-1:POS_SHIFT];
      pos_base = (op_ff == OP_X) ? pos_x_ff : pos_y_ff;
      pos_sum  = sat_add(pos_base, pos_step);
   end

   assign hd_wide = {heading_ff, 16'b0} >> ANGLE_BITS;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      chunk_in       = chunk_ff;
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      heading_in     = heading_ff;
      du_in          = du_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_load       = 1'b0;
      take_update    = 1'b0;
      cordic_start   = 1'b0;
      mac_ctl        = '0;
      mac_ctl.rnd    = rnd_of(op_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_action)
                  ACT_LEFT:  left_count_in  = cnt_step(left_count_ff, !same);
                  ACT_RIGHT: right_count_in = cnt_step(right_count_ff, same);
                  ACT_UPDATE: begin
                     take_update    = 1'b1;
                     left_count_in  = '0;
                     right_count_in = '0;
                     op_in          = OP_HEAD;
                     chunk_in       = 1'b0;
                     state_in       = ST_MUL;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            mac_ctl.mul_en = 1'b1;
            state_in       = ST_ACC;
         end
         ST_ACC: begin
            mac_ctl.acc_en    = 1'b1;
            mac_ctl.acc_first = !chunk_ff;
            mac_ctl.acc_last  = chunk_ff;
            if (!chunk_ff) begin
               chunk_in = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            chunk_in = 1'b0;
            case (op_ff)
               OP_HEAD: begin
                  heading_in = heading_ff + mac_acc[ANGLE_BITS+HEAD_SHIFT-1:HEAD_SHIFT];
                  op_in      = OP_DIST;
                  state_in   = ST_MUL;
               end
               OP_DIST: begin
                  du_in        = du_c;
                  cordic_start = 1'b1;
                  state_in     = ST_CORD;
               end
               OP_X: begin
                  pos_x_in = pos_sum;
                  op_in    = OP_Y;
                  state_in = ST_MUL;
               end
               default: begin
                  pos_y_in = pos_sum;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_CORD: begin
            if (cstat.done) begin
               op_in    = OP_X;
               chunk_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         op_ff               <= OP_HEAD;
         chunk_ff            <= 1'b0;
         left_count_ff       <= '0;
         right_count_ff      <= '0;
         heading_ff          <= '0;
         pos_x_ff            <= '0;
         pos_y_ff            <= '0;
         rsp_valid_ff        <= 1'b0;
         mm_per_tick_ff      <= MM_PER_TICK_RST;
         heading_per_tick_ff <= HEADING_PER_TICK_RST;
      end else begin
         state_ff       <= state_in;
         op_ff          <= op_in;
         chunk_ff       <= chunk_in;
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
         heading_ff     <= heading_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MM_PER_TICK:      mm_per_tick_ff      <= csr_wdata;
               CSR_HEADING_PER_TICK: heading_per_tick_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload: taken counts, travel and response
   always_ff @(posedge clock) begin
      if (take_update) begin
         take_l_ff <= left_count_ff;
         take_r_ff <= right_count_ff;
         sum_ff    <= MAC_A_W'(left_count_ff) + MAC_A_W'(right_count_ff);
         diff_ff   <= MAC_A_W'(left_count_ff) - MAC_A_W'(right_count_ff);
      end
      du_ff <= du_in;
      if (rsp_load) begin
         rsp_data_ff <= {sat16(33'(take_r_ff)), sat16(33'(take_l_ff)), hd_wide[15:0],
                         pos_y_ff, pos_x_ff};
      end
   end

   ddo_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   ddo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   ({heading_ff, {(32-ANGLE_BITS){1'b0}}}),
      .sin_q30 (sin_q30),
      .cos_q30 (cos_q30),
      .stat    (cstat)
   );

   `DDO_ASSERT_NXT(a_take_clears, take_update, left_count_ff == '0 && right_count_ff == '0)
   `DDO_ASSERT_NXT(a_head_hold, !(state_ff == ST_POST && op_ff == OP_HEAD), $stable(heading_ff))
   `DDO_ASSERT_IMP(a_rsp_src, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `DDO_ASSERT_IMP(a_cordic_free, cordic_start, !cstat.busy)

endmodule

// ===== design/ddo_mac.sv =====
// Shared multiply-accumulate unit: one 34x17 signed product per pass, two passes
// per full product, most significant chunk first. Depends on ddo_pkg.
module ddo_mac (
   input  logic                                 clock,
   input  ddo_pkg::mac_ctl_type                 ctl,
   input  logic signed [ddo_pkg::MAC_A_W-1:0]   op_a,
   input  logic signed [ddo_pkg::MAC_B_W-1:0]   op_b,
   output logic signed [ddo_pkg::MAC_ACC_W-1:0] acc
);
   import ddo_pkg::*;

   logic signed [MAC_A_W+MAC_B_W-1:0] prod_ff;
   logic signed [MAC_ACC_W-1:0]       acc_ff;
   logic signed [MAC_ACC_W-1:0]       acc_in;

   // shift the partial sum up one chunk, add the product, add rounding on the last pass
   always_comb begin
      acc_in = (ctl.acc_first ? '0 : (acc_ff <<< MAC_CHUNK)) + MAC_ACC_W'(prod_ff)
             + (ctl.acc_last ? rnd_bias(ctl.rnd) : '0);
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= op_a * op_b;
      end
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== design/ddo_cordic.sv =====
// Iterative 24-step rotation CORDIC giving sine and cosine in Q30 of a 32-bit
// binary angle, one micro-rotation per cycle. Depends on ddo_pkg and the macros.
`include "differential_drive_odometry_macros.svh"
module ddo_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              angle,
   output logic signed [31:0]       sin_q30,
   output logic signed [31:0]       cos_q30,
   output ddo_pkg::cordic_stat_type stat
);
   import ddo_pkg::*;

   localparam logic [CORDIC_STEP_W-1:0] STEP_LAST = CORDIC_STEP_W'(CORDIC_STEPS - 1);

   logic signed [31:0]       x_ff, x_in;
   logic signed [31:0]       y_ff, y_in;
   logic signed [31:0]       z_ff, z_in;
   logic [1:0]               quad_ff;
   logic [CORDIC_STEP_W-1:0] step_ff, step_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff;
   logic signed [31:0]       dx, dy, atan_v;
   logic                     last_step;

   assign last_step = busy_ff && (step_ff == STEP_LAST);

   // one micro-rotation toward zero residual angle
   always_comb begin
      dx     = y_ff >>> step_ff;
      dy     = x_ff >>> step_ff;
      atan_v = cordic_atan(step_ff);
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      if (!z_ff[31]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - atan_v;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + atan_v;
      end
      step_in = step_ff + 1'b1;
      busy_in = busy_ff ? !last_step : start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= last_step;
         if (busy_ff) begin
            step_ff <= step_in;
         end else if (start) begin
            step_ff <= '0;
         end
      end
   end

   // load the quarter-turn residue or advance the rotation
   always_ff @(posedge clock) begin
      if (!busy_ff && start) begin
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= {2'b00, angle[29:0]};
         quad_ff <= angle[31:30];
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   // swap into the quadrant of the angle
   always_comb begin
      case (quad_ff)
         2'd0: begin
            cos_q30 = x_ff;
            sin_q30 = y_ff;
         end
         2'd1: begin
            cos_q30 = -y_ff;
            sin_q30 = x_ff;
         end
         2'd2: begin
            cos_q30 = -x_ff;
            sin_q30 = -y_ff;
         end
         default: begin
            cos_q30 = y_ff;
            sin_q30 = -x_ff;
         end
      endcase
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `DDO_ASSERT_NXT(a_start_busy, start && !busy_ff, busy_ff && step_ff == '0)
   `DDO_ASSERT_NXT(a_finish, last_step, !busy_ff && done_ff)
   `DDO_ASSERT_IMP(a_done_idle, done_ff, !busy_ff)

endmodule
